/* rtl/pvct_pkg.sv */
// Package for the persistent connection tracker: command and status codes,
// sizes, the result record and a population count helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvct_pkg;

  // Sizes; field widths are fixed by the port definitions
  localparam int Frames   = 16;
  localparam int Conns    = 64;
  localparam int MaskW    = 64;
  localparam int FrameW   = 4;
  localparam int ConnW    = 6;
  localparam int CmdW     = 3;
  localparam int CountW   = 7;
  localparam int StatusW  = 2;

  localparam logic [MaskW-1:0] ConnMask =
    (Conns >= MaskW) ? {MaskW{1'b1}} : ((MaskW'(1) << Conns) - MaskW'(1));

  // Commands
  localparam logic [CmdW-1:0] CmdUpdate   = 3'd0;
  localparam logic [CmdW-1:0] CmdSilence  = 3'd1;
  localparam logic [CmdW-1:0] CmdRelocate = 3'd2;
  localparam logic [CmdW-1:0] CmdUnserved = 3'd3;
  localparam logic [CmdW-1:0] CmdServed   = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] StatusOk         = 2'd0;
  localparam logic [StatusW-1:0] StatusFrameRange = 2'd1;
  localparam logic [StatusW-1:0] StatusPrecond    = 2'd2;

  typedef struct packed {
    logic [MaskW-1:0]   new_mask;
    logic [MaskW-1:0]   reactivated_mask;
    logic [MaskW-1:0]   persistent_mask;
    logic [MaskW-1:0]   unpersistent_mask;
    logic [MaskW-1:0]   silenced_mask;
    logic [MaskW-1:0]   other_frame_mask;
    logic [CountW-1:0]  app_active_count;
    logic [CountW-1:0]  frame_active_count;
    logic [CountW-1:0]  queued_count;
    logic [StatusW-1:0] status;
  } result_t;

  // Byte-wise counts, then a sum of eight narrow values
  function automatic logic [CountW-1:0] popcount(input logic [MaskW-1:0] v);
    logic [3:0]        byte_cnt [MaskW/8];
    logic [CountW-1:0] sum;
    sum = '0;
    for (int i = 0; i < MaskW / 8; i++) begin
      byte_cnt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[i] = byte_cnt[i] + {3'd0, v[i*8+j]};
      end
    end
    for (int i = 0; i < MaskW / 8; i++) begin
      sum = sum + {3'd0, byte_cnt[i]};
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

/* rtl/persistent_voip_connection_tracker.sv */
// Persistent connection tracker top level: request register, single-pass set
// logic with state update, result register. Depends on pvct_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Handshake               | Payload
//  ---------+-------------------------+--------------------------------------------
//  request  | in_valid_i / in_stall_o | command, active_mask, frame, target_frame,
//           |                         | connection
//  result   | out_valid_o/out_stall_i | six connection masks, three counts, status
//
//  One request per cycle sustained while the result side is not stalled; each request
//  is held in the request register and moves into the result register when it fires.
//  The set logic and 64-bit popcounts between the two registers set the cycle.
//  Reset clears every per-frame and global connection set.
//  A stalled result holds both stages; the request side stalls only when both
//  stages are full.
module persistent_voip_connection_tracker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [pvct_pkg::CmdW-1:0]    command_i,
  input  wire  [pvct_pkg::MaskW-1:0]   active_mask_i,
  input  wire  [pvct_pkg::FrameW-1:0]  frame_i,
  input  wire  [pvct_pkg::FrameW-1:0]  target_frame_i,
  input  wire  [pvct_pkg::ConnW-1:0]   connection_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [pvct_pkg::MaskW-1:0]   new_mask_o,
  output logic [pvct_pkg::MaskW-1:0]   reactivated_mask_o,
  output logic [pvct_pkg::MaskW-1:0]   persistent_mask_o,
  output logic [pvct_pkg::MaskW-1:0]   unpersistent_mask_o,
  output logic [pvct_pkg::MaskW-1:0]   silenced_mask_o,
  output logic [pvct_pkg::MaskW-1:0]   other_frame_mask_o,
  output logic [pvct_pkg::CountW-1:0]  app_active_count_o,
  output logic [pvct_pkg::CountW-1:0]  frame_active_count_o,
  output logic [pvct_pkg::CountW-1:0]  queued_count_o,
  output logic [pvct_pkg::StatusW-1:0] status_o
);
  import pvct_pkg::*;

  // Request register
  logic              req_valid_q;
  logic [CmdW-1:0]   cmd_q;
  logic [MaskW-1:0]  act_q;
  logic [FrameW-1:0] frame_q;
  logic [FrameW-1:0] target_q;
  logic [ConnW-1:0]  conn_q;

  // Result register
  logic    res_valid_q;
  result_t res_q, res_d;

  // Connection sets
  logic [MaskW-1:0] expected_q [Frames];
  logic [MaskW-1:0] recent_q   [Frames];
  logic [MaskW-1:0] reloc_q    [Frames];
  logic [MaskW-1:0] owner_q    [Frames];
  logic [MaskW-1:0] expected_d [Frames];
  logic [MaskW-1:0] recent_d   [Frames];
  logic [MaskW-1:0] reloc_d    [Frames];
  logic [MaskW-1:0] owner_d    [Frames];
  logic [MaskW-1:0] assigned_q, assigned_d;
  logic [MaskW-1:0] known_q, known_d;
  logic [MaskW-1:0] silent_q, silent_d;
  logic [MaskW-1:0] unserved_q, unserved_d;

  logic res_load;
  logic req_load;
  logic req_fire;

  assign res_load   = !res_valid_q || !out_stall_i;
  assign req_fire   = req_valid_q && res_load;
  assign in_stall_o = req_valid_q && !res_load;
  assign req_load   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      cmd_q    <= command_i;
      act_q    <= active_mask_i;
      frame_q  <= frame_i;
      target_q <= target_frame_i;
      conn_q   <= connection_i;
    end
  end

  // Single pass over the held request
  always_comb begin
    logic [MaskW-1:0]  act, bit_c, foreign, inframe, exp, rec;
    logic [MaskW-1:0]  old, sil, unknown, newc, first, unexp, react, maybe;
    logic [CountW-1:0] nin, nrel;
    logic              frame_bad, conn_bad;

    for (int i = 0; i < Frames; i++) begin
      expected_d[i] = expected_q[i];
      recent_d[i]   = recent_q[i];
      reloc_d[i]    = reloc_q[i];
      owner_d[i]    = owner_q[i];
    end
    assigned_d = assigned_q;
    known_d    = known_q;
    silent_d   = silent_q;
    unserved_d = unserved_q;
    res_d      = '0;

    act       = act_q & ConnMask;
    bit_c     = MaskW'(1) << conn_q;
    frame_bad = (int'(frame_q) >= Frames) ||
                ((cmd_q == CmdRelocate) && (int'(target_q) >= Frames));
    conn_bad  = int'(conn_q) >= Conns;

    foreign = act & assigned_q & ~owner_q[frame_q];
    inframe = act & ~foreign;
    exp     = expected_q[frame_q];
    rec     = recent_q[frame_q];
    old     = exp & inframe;
    sil     = exp & ~inframe;
    unknown = inframe & ~known_q;
    newc    = unknown & rec;
    first   = unknown & ~newc;
    unexp   = (inframe & known_q) & ~exp;
    react   = unexp & rec;
    maybe   = unexp & ~rec & silent_q;
    nin     = popcount(inframe);
    nrel    = popcount(reloc_q[frame_q]);

    unique case (cmd_q) inside
      CmdUpdate, CmdSilence, CmdRelocate, CmdUnserved, CmdServed: begin
        if (cmd_q != CmdUnserved && cmd_q != CmdServed && frame_bad) begin
          res_d.status = StatusFrameRange;
        end else if (cmd_q == CmdUpdate) begin
          if (act == '0 && exp == '0) begin
            // Nothing talking and nothing expected: forget the recent set
            recent_d[frame_q] = '0;
          end else if ((react & ~silent_q) != '0 || (newc & assigned_q) != '0) begin
            res_d.status = StatusPrecond;
          end else begin
            known_d             = known_q | newc;
            silent_d            = (silent_q & ~react) | sil;
            recent_d[frame_q]   = first | maybe;
            expected_d[frame_q] = old | newc | react;
            owner_d[frame_q]    = owner_q[frame_q] | newc;
            assigned_d          = assigned_q | newc;
            res_d.new_mask           = newc;
            res_d.reactivated_mask   = react;
            res_d.persistent_mask    = old;
            res_d.unpersistent_mask  = first | maybe;
            res_d.silenced_mask      = sil;
            res_d.other_frame_mask   = foreign & unserved_q;
            res_d.app_active_count   = (nin > nrel) ? nin - nrel : '0;
            res_d.frame_active_count = nin;
            res_d.queued_count       = popcount(act);
          end
        end else if (conn_bad) begin
          res_d.status = StatusPrecond;
        end else if (cmd_q == CmdSilence) begin
          if ((silent_q & bit_c) != '0 || (exp & bit_c) == '0) begin
            res_d.status = StatusPrecond;
          end else begin
            expected_d[frame_q] = exp & ~bit_c;
            reloc_d[frame_q]    = reloc_q[frame_q] & ~bit_c;
            silent_d            = silent_q | bit_c;
          end
        end else if (cmd_q == CmdRelocate) begin
          if ((assigned_q & bit_c) == '0 || (owner_q[frame_q] & bit_c) == '0 ||
              (silent_q & bit_c) == '0) begin
            res_d.status = StatusPrecond;
          end else begin
            // Move ownership: drop the bit everywhere, set it in the target frame
            for (int i = 0; i < Frames; i++) begin
              owner_d[i] = owner_q[i] & ~bit_c;
            end
            owner_d[target_q]  = owner_d[target_q] | bit_c;
            recent_d[target_q] = recent_q[target_q] | bit_c;
            reloc_d[target_q]  = reloc_q[target_q] | bit_c;
          end
        end else if (cmd_q == CmdUnserved) begin
          unserved_d = unserved_q | bit_c;
        end else begin
          if ((unserved_q & bit_c) == '0) begin
            res_d.status = StatusPrecond;
          end else begin
            unserved_d = unserved_q & ~bit_c;
          end
        end
      end
      default: begin
        res_d.status = StatusPrecond;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Frames; i++) begin
        expected_q[i] <= '0;
        recent_q[i]   <= '0;
        reloc_q[i]    <= '0;
        owner_q[i]    <= '0;
      end
      assigned_q <= '0;
      known_q    <= '0;
      silent_q   <= '0;
      unserved_q <= '0;
    end else if (req_fire) begin
      for (int i = 0; i < Frames; i++) begin
        expected_q[i] <= expected_d[i];
        recent_q[i]   <= recent_d[i];
        reloc_q[i]    <= reloc_d[i];
        owner_q[i]    <= owner_d[i];
      end
      assigned_q <= assigned_d;
      known_q    <= known_d;
      silent_q   <= silent_d;
      unserved_q <= unserved_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign new_mask_o           = res_q.new_mask;
  assign reactivated_mask_o   = res_q.reactivated_mask;
  assign persistent_mask_o    = res_q.persistent_mask;
  assign unpersistent_mask_o  = res_q.unpersistent_mask;
  assign silenced_mask_o      = res_q.silenced_mask;
  assign other_frame_mask_o   = res_q.other_frame_mask;
  assign app_active_count_o   = res_q.app_active_count;
  assign frame_active_count_o = res_q.frame_active_count;
  assign queued_count_o       = res_q.queued_count;
  assign status_o             = res_q.status;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for persistent_voip_connection_tracker: directed and random
// requests with bursty sending and patterned result stalls. Depends on pvct_pkg.
`timescale 1ns / 1ps

module tb_top;
  import pvct_pkg::*;

  localparam int RandomRequests = 1130;
  localparam int QuietLimit     = 2000;
  localparam int TailCycles     = 8;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [MaskW-1:0]  active;
    logic [FrameW-1:0] frame;
    logic [FrameW-1:0] target;
    logic [ConnW-1:0]  conn;
  } request_t;

  // Holds its own copy of the connection sets and the reports still owed by the block
  class conn_set_scoreboard;
    logic [MaskW-1:0] expected_by_frame  [Frames];
    logic [MaskW-1:0] recent_by_frame    [Frames];
    logic [MaskW-1:0] relocated_by_frame [Frames];
    logic [MaskW-1:0] owner_by_frame     [Frames];
    logic [MaskW-1:0] owned_conns, known_conns, silent_conns, unserved_conns;
    result_t owed_reports[$];
    int errors, requests, reports;
    int seen_new, seen_react, seen_silenced, seen_other, seen_rejected;

    function new();
      for (int f = 0; f < Frames; f++) begin
        expected_by_frame[f]  = '0;
        recent_by_frame[f]    = '0;
        relocated_by_frame[f] = '0;
        owner_by_frame[f]     = '0;
      end
      owned_conns = '0;
      known_conns = '0;
      silent_conns = '0;
      unserved_conns = '0;
      errors = 0;
      requests = 0;
      reports = 0;
      seen_new = 0;
      seen_react = 0;
      seen_silenced = 0;
      seen_other = 0;
      seen_rejected = 0;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    function result_t classify_request(request_t r);
      result_t res;
      logic [MaskW-1:0] bit_c, act, foreign, inframe, expd, rec;
      logic [MaskW-1:0] old, sil, unknown, newc, first, unexp, react, maybe;
      int f, nin, nrel;
      res = '0;
      f = r.frame;
      bit_c = MaskW'(1) << r.conn;
      act = r.active & ConnMask;
      if (r.command > CmdServed) begin
        res.status = StatusPrecond;
      end else if (r.command <= CmdRelocate &&
                   (r.frame >= Frames || (r.command == CmdRelocate && r.target >= Frames))) begin
        res.status = StatusFrameRange;
      end else if (r.command == CmdUpdate) begin
        foreign = act & owned_conns & ~owner_by_frame[f];
        inframe = act & ~foreign;
        expd = expected_by_frame[f];
        rec = recent_by_frame[f];
        if (act == '0 && expd == '0) begin
          recent_by_frame[f] = '0;
        end else begin
          old = expd & inframe;
          sil = expd & ~inframe;
          unknown = inframe & ~known_conns;
          newc = unknown & rec;
          first = unknown & ~newc;
          unexp = (inframe & known_conns) & ~expd;
          react = unexp & rec;
          maybe = unexp & ~rec & silent_conns;
          if ((react & ~silent_conns) != '0 || (newc & owned_conns) != '0) begin
            res.status = StatusPrecond;
          end else begin
            known_conns |= newc;
            silent_conns = (silent_conns & ~react) | sil;
            recent_by_frame[f] = first | maybe;
            expected_by_frame[f] = old | newc | react;
            owner_by_frame[f] |= newc;
            owned_conns |= newc;
            nin = $countones(inframe);
            nrel = $countones(relocated_by_frame[f]);
            res.new_mask = newc;
            res.reactivated_mask = react;
            res.persistent_mask = old;
            res.unpersistent_mask = recent_by_frame[f];
            res.silenced_mask = sil;
            res.other_frame_mask = foreign & unserved_conns;
            res.app_active_count = (nin > nrel) ? CountW'(nin - nrel) : '0;
            res.frame_active_count = CountW'(nin);
            res.queued_count = CountW'($countones(act));
            if (newc != '0) seen_new++;
            if (react != '0) seen_react++;
            if (sil != '0) seen_silenced++;
            if (res.other_frame_mask != '0) seen_other++;
          end
        end
      end else if (r.conn >= Conns) begin
        res.status = StatusPrecond;
      end else if (r.command == CmdSilence) begin
        if ((silent_conns & bit_c) != '0 || (expected_by_frame[f] & bit_c) == '0) begin
          res.status = StatusPrecond;
        end else begin
          expected_by_frame[f] &= ~bit_c;
          relocated_by_frame[f] &= ~bit_c;
          silent_conns |= bit_c;
        end
      end else if (r.command == CmdRelocate) begin
        if ((owned_conns & bit_c) == '0 || (owner_by_frame[f] & bit_c) == '0 ||
            (silent_conns & bit_c) == '0) begin
          res.status = StatusPrecond;
        end else begin
          for (int i = 0; i < Frames; i++) owner_by_frame[i] &= ~bit_c;
          owner_by_frame[r.target] |= bit_c;
          recent_by_frame[r.target] |= bit_c;
          relocated_by_frame[r.target] |= bit_c;
        end
      end else if (r.command == CmdUnserved) begin
        unserved_conns |= bit_c;
      end else begin
        if ((unserved_conns & bit_c) == '0) res.status = StatusPrecond;
        else unserved_conns &= ~bit_c;
      end
      if (res.status != StatusOk) seen_rejected++;
      return res;
    endfunction

    function void note_request(request_t r);
      owed_reports.push_back(classify_request(r));
      requests++;
    endfunction

    function void compare_field(string name, logic [MaskW-1:0] want, logic [MaskW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      reports++;
      if (owed_reports.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, got status %0d",
                 $time, got.status);
        return;
      end
      want = owed_reports.pop_front();
      compare_field("new_mask", want.new_mask, got.new_mask);
      compare_field("reactivated_mask", want.reactivated_mask, got.reactivated_mask);
      compare_field("persistent_mask", want.persistent_mask, got.persistent_mask);
      compare_field("unpersistent_mask", want.unpersistent_mask, got.unpersistent_mask);
      compare_field("silenced_mask", want.silenced_mask, got.silenced_mask);
      compare_field("other_frame_mask", want.other_frame_mask, got.other_frame_mask);
      compare_field("app_active_count", MaskW'(want.app_active_count),
                    MaskW'(got.app_active_count));
      compare_field("frame_active_count", MaskW'(want.frame_active_count),
                    MaskW'(got.frame_active_count));
      compare_field("queued_count", MaskW'(want.queued_count), MaskW'(got.queued_count));
      compare_field("status", MaskW'(want.status), MaskW'(got.status));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CmdW-1:0]    command_i;
  logic [MaskW-1:0]   active_mask_i;
  logic [FrameW-1:0]  frame_i;
  logic [FrameW-1:0]  target_frame_i;
  logic [ConnW-1:0]   connection_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [MaskW-1:0]   new_mask_o, reactivated_mask_o, persistent_mask_o;
  logic [MaskW-1:0]   unpersistent_mask_o, silenced_mask_o, other_frame_mask_o;
  logic [CountW-1:0]  app_active_count_o, frame_active_count_o, queued_count_o;
  logic [StatusW-1:0] status_o;

  result_t dut_result;
  logic    in_fire, out_fire;
  int      quiet_cycles;
  int      stall_mode, mode_left, stall_phase;
  logic [MaskW-1:0] traffic_profile [Frames];
  conn_set_scoreboard sb;

  persistent_voip_connection_tracker DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .command_i, .active_mask_i, .frame_i, .target_frame_i, .connection_i,
    .out_valid_o, .out_stall_i,
    .new_mask_o, .reactivated_mask_o, .persistent_mask_o, .unpersistent_mask_o,
    .silenced_mask_o, .other_frame_mask_o,
    .app_active_count_o, .frame_active_count_o, .queued_count_o, .status_o
  );

  assign dut_result = {new_mask_o, reactivated_mask_o, persistent_mask_o, unpersistent_mask_o,
                       silenced_mask_o, other_frame_mask_o, app_active_count_o,
                       frame_active_count_o, queued_count_o, status_o};
  assign in_fire  = in_valid_i && (in_stall_o === 1'b0);
  assign out_fire = (out_valid_o === 1'b1) && !out_stall_i;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Drive one request and hold it until the block takes it
  task automatic push_request(input request_t r);
    in_valid_i     <= 1'b1;
    command_i      <= r.command;
    active_mask_i  <= r.active;
    frame_i        <= r.frame;
    target_frame_i <= r.target;
    connection_i   <= r.conn;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic send(input logic [CmdW-1:0] cmd, input logic [MaskW-1:0] act,
                      input int frame, input int target, input int conn);
    request_t r;
    r.command = cmd;
    r.active  = act;
    r.frame   = FrameW'(frame);
    r.target  = FrameW'(target);
    r.conn    = ConnW'(conn);
    push_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic int pick_conn(logic [MaskW-1:0] pool);
    int start;
    start = $urandom_range(0, Conns - 1);
    for (int k = 0; k < Conns; k++)
      if (pool[(start + k) % Conns]) return (start + k) % Conns;
    return start;
  endfunction

  // Find a frame that has a connection fit to silence, or fit to relocate
  function automatic bit frame_with(input bit movable, output int frame_idx,
                                    output logic [MaskW-1:0] pool);
    int start;
    start = $urandom_range(0, Frames - 1);
    frame_idx = start;
    pool = '0;
    for (int k = 0; k < Frames; k++) begin
      frame_idx = (start + k) % Frames;
      pool = movable ? (sb.owner_by_frame[frame_idx] & sb.silent_conns)
                     : (sb.expected_by_frame[frame_idx] & ~sb.silent_conns);
      if (pool != '0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic request_t next_request();
    request_t r;
    logic [MaskW-1:0] pool;
    int roll, f;
    r.command = CmdUpdate;
    r.active  = {$urandom, $urandom};
    r.frame   = FrameW'($urandom_range(0, Frames - 1));
    r.target  = FrameW'($urandom_range(0, Frames - 1));
    r.conn    = ConnW'($urandom_range(0, Conns - 1));
    roll = $urandom_range(0, 99);
    if (roll < 68) begin
      // keep most traffic on a few frames so connections get confirmed
      if ($urandom_range(0, 3) != 0) r.frame = FrameW'($urandom_range(0, 5));
      f = r.frame;
      case ($urandom_range(0, 19))
        0: r.active = '0;
        1: r.active = '1;
        2: ;
        default: begin
          if ($urandom_range(0, 1) != 0)
            traffic_profile[f][$urandom_range(0, Conns - 1)] ^= 1'b1;
          r.active = traffic_profile[f];
        end
      endcase
    end else if (roll < 80) begin
      r.command = CmdSilence;
      if ($urandom_range(0, 6) != 0 && frame_with(1'b0, f, pool)) begin
        r.frame = FrameW'(f);
        r.conn  = ConnW'(pick_conn(pool));
      end
    end else if (roll < 89) begin
      r.command = CmdRelocate;
      if ($urandom_range(0, 6) != 0 && frame_with(1'b1, f, pool)) begin
        r.frame = FrameW'(f);
        r.conn  = ConnW'(pick_conn(pool));
      end
    end else if (roll < 94) begin
      r.command = CmdUnserved;
    end else if (roll < 98) begin
      r.command = CmdServed;
      if (sb.unserved_conns != '0 && $urandom_range(0, 4) != 0)
        r.conn = ConnW'(pick_conn(sb.unserved_conns));
    end else begin
      r.command = CmdW'($urandom_range(CmdServed + 1, (1 << CmdW) - 1));
    end
    return r;
  endfunction

  // Result side: check every taken result, stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) sb.check_result(dut_result);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ((stall_phase % 5) < 2);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QuietLimit, sb.pending());
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int burst_left, gap;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CmdUpdate;
    active_mask_i = '0;
    frame_i = '0;
    target_frame_i = '0;
    connection_i = '0;
    out_stall_i = 1'b0;
    quiet_cycles = 0;
    stall_mode = 0;
    mode_left = 0;
    stall_phase = 0;
    burst_left = 0;
    for (int f = 0; f < Frames; f++)
      traffic_profile[f] = {$urandom, $urandom} & {$urandom, $urandom};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through the classification and several rejection paths
    send(CmdUpdate, '0, 0, 0, 0);                         // empty update
    send(CmdRelocate, '0, 1, 4, 9);                       // no owner yet
    send(CmdUpdate, '1, 15, 0, 63);                       // all seen for the first time
    send(CmdUpdate, 64'h8000_0000_0000_00ff, 15, 15, 0);  // confirm a subset as new
    send(CmdUnserved, '0, 0, 0, 0);
    send(CmdUnserved, '0, 0, 0, 63);
    send(CmdUpdate, '1, 0, 0, 0);                         // owned ones are other-frame
    send(CmdServed, '0, 0, 0, 0);
    send(CmdServed, '0, 0, 0, 0);                         // mark already cleared
    send(CmdUpdate, 64'h0000_0000_0000_00ff, 15, 0, 0);   // drop 63: silenced
    send(CmdSilence, '0, 15, 0, 5);
    send(CmdSilence, '0, 15, 0, 5);                       // already silent
    send(CmdSilence, '0, 3, 0, 6);                        // not expected there
    send(CmdRelocate, '0, 15, 2, 5);
    send(CmdRelocate, '0, 15, 0, 5);                      // now owned elsewhere
    send(CmdRelocate, '0, 15, 0, 7);                      // still talking
    send(CmdRelocate, '0, 15, 0, 63);
    send(CmdUpdate, 64'd1 << 5, 2, 0, 0);                 // reactivated after relocation
    send(CmdUpdate, '0, 2, 0, 0);                         // count floors at zero
    send(CmdUpdate, 64'h8000_ffff_0000_0000, 0, 15, 0);
    for (int c = CmdServed + 1; c < (1 << CmdW); c++)
      send(CmdW'(c), {$urandom, $urandom}, $urandom_range(0, 15), $urandom_range(0, 15),
           $urandom_range(0, 63));
    drain();

    for (int n = 0; n < RandomRequests; n++) begin
      if (n == RandomRequests / 2) begin
        drain();
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      push_request(next_request());
      if (burst_left != 0) burst_left--;
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d requests (%0d rejected), %0d results checked",
             sb.requests, sb.seen_rejected, sb.reports);
    $display("updates with new %0d, reactivated %0d, silenced %0d, other-frame %0d",
             sb.seen_new, sb.seen_react, sb.seen_silenced, sb.seen_other);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
